// ===== rtl/lmc_pkg.sv =====
// Shared types, constants and the instruction decoder of the little man computer core.
package lmc_pkg;

  localparam int MBOX_COUNT = 100;
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [WORD_W-1:0] INS_HALT  = 16'd0;
  localparam logic [WORD_W-1:0] INS_IN    = 16'd901;
  localparam logic [WORD_W-1:0] INS_OUT   = 16'd902;
  localparam logic [WORD_W-1:0] INS_LIMIT = 16'd1000;

  localparam logic [3:0] DIG_ADD = 4'd1;
  localparam logic [3:0] DIG_SUB = 4'd2;
  localparam logic [3:0] DIG_STO = 4'd3;
  localparam logic [3:0] DIG_LDA = 4'd5;
  localparam logic [3:0] DIG_BRA = 4'd6;
  localparam logic [3:0] DIG_BRZ = 4'd7;
  localparam logic [3:0] DIG_BRP = 4'd8;

  localparam logic [9:0] HUND_BASE [10] = '{10'd0, 10'd100, 10'd200, 10'd300, 10'd400,
                                           10'd500, 10'd600, 10'd700, 10'd800, 10'd900};

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_END  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_HALT = 4'd0,
    OP_IN   = 4'd1,
    OP_OUT  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_STO  = 4'd5,
    OP_LDA  = 4'd6,
    OP_BRA  = 4'd7,
    OP_BRZ  = 4'd8,
    OP_BRP  = 4'd9,
    OP_BAD  = 4'd10
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] xx;
  } dec_t;

  typedef struct packed {
    logic                     cmd;
    logic [ADDR_W-1:0]        load_addr;
    logic signed [WORD_W-1:0] load_word;
    logic signed [WORD_W-1:0] inbox_value;
  } in_item_t;

  typedef struct packed {
    logic                     out_valid;
    logic signed [WORD_W-1:0] out_value;
    logic                     inbox_used;
    status_t                  run_status;
    logic [ADDR_W-1:0]        pc_now;
    logic signed [WORD_W-1:0] acc_now;
    logic                     neg_now;
  } out_item_t;

  function automatic dec_t decode(input logic [WORD_W-1:0] w);
    dec_t       d;
    logic [3:0] hund;
    logic [9:0] low;
    low  = w[9:0];
    hund = '0;
    for (int k = 1; k < 10; k++) begin
      if (low >= HUND_BASE[k]) hund = 4'(k);
    end
    d.xx = ADDR_W'(low - HUND_BASE[hund]);
    if (w[WORD_W-1] || w >= INS_LIMIT) begin
      d.op = OP_BAD;
    end else if (w == INS_HALT) begin
      d.op = OP_HALT;
    end else if (w == INS_IN) begin
      d.op = OP_IN;
    end else if (w == INS_OUT) begin
      d.op = OP_OUT;
    end else begin
      unique case (hund)
        DIG_ADD: d.op = OP_ADD;
        DIG_SUB: d.op = OP_SUB;
        DIG_STO: d.op = OP_STO;
        DIG_LDA: d.op = OP_LDA;
        DIG_BRA: d.op = OP_BRA;
        DIG_BRZ: d.op = OP_BRZ;
        DIG_BRP: d.op = OP_BRP;
        default: d.op = OP_BAD;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== rtl/lmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/little_man_computer_core_top.sv =====
// Top level of the little man computer core: command buffer, sequencer and mailbox memory.
//
// Each transaction is a command and returns exactly one result. A load command is written
// and answered from the idle state. A step command passes in order through instruction
// read from the mailbox memory, decode with the operand read, then execute with the
// write-back of a store; the single read port of the mailbox memory and the dependence of
// each step on the program counter left by the previous one keep these phases apart.
// Steps on a stopped machine are answered from the idle state without a fetch. A
// one-entry command buffer takes the next transaction while the current one is executing,
// and a result register holds a finished result until it is taken. The mailboxes read as
// zero after reset through per-entry valid bits, so no clearing pass is needed.
module little_man_computer_core_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmc_pkg::in_item_t    in_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lmc_pkg::out_item_t   res_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t                          state, state_next;
  logic [lmc_pkg::ADDR_W-1:0]      pc, pc_next;
  logic [lmc_pkg::WORD_W-1:0]      acc, acc_next;
  logic                            neg, neg_next;
  lmc_pkg::status_t                status, status_next;
  logic [lmc_pkg::MBOX_COUNT-1:0]  vbit;

  logic                            ib_valid;
  lmc_pkg::in_item_t               ib;
  logic [lmc_pkg::WORD_W-1:0]      cur_inbox;
  lmc_pkg::dec_t                   dec;
  lmc_pkg::dec_t                   dec_now;
  logic                            rd_ok;

  logic                            ram_we, ram_re;
  logic [lmc_pkg::ADDR_W-1:0]      waddr, raddr;
  logic [lmc_pkg::WORD_W-1:0]      wdata, rdata, mem_word;
  logic [lmc_pkg::WORD_W-1:0]      diff;
  logic [lmc_pkg::ADDR_W-1:0]      pc_inc;

  logic                            pop, cur_ld, res_ld, adv, out_free, running;
  lmc_pkg::out_item_t              res_next;

  lmc_ram #(
    .WIDTH(lmc_pkg::WORD_W),
    .DEPTH(lmc_pkg::MBOX_COUNT)
  ) u_mbox (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_free = !res_valid || res_ready;
  assign running  = (status == lmc_pkg::ST_RUN);
  assign in_ready = !ib_valid || pop;
  assign mem_word = rd_ok ? rdata : '0;
  assign dec_now  = lmc_pkg::decode(mem_word);
  assign diff     = acc - mem_word;
  assign pc_inc   = pc + lmc_pkg::ADDR_W'(1);

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    acc_next    = acc;
    neg_next    = neg;
    status_next = status;
    ram_we      = 1'b0;
    waddr       = ib.load_addr;
    wdata       = ib.load_word;
    ram_re      = 1'b0;
    raddr       = pc;
    pop         = 1'b0;
    cur_ld      = 1'b0;
    res_ld      = 1'b0;
    adv         = 1'b0;
    res_next    = '0;
    unique case (state)
      S_IDLE: begin
        if (ib_valid) begin
          if (ib.cmd == lmc_pkg::CMD_STEP && running) begin
            pop        = 1'b1;
            ram_re     = 1'b1;
            cur_ld     = 1'b1;
            state_next = S_FETCH;
          end else if (out_free) begin
            pop    = 1'b1;
            res_ld = 1'b1;
            if (ib.cmd == lmc_pkg::CMD_LOAD &&
                ib.load_addr < lmc_pkg::ADDR_W'(lmc_pkg::MBOX_COUNT)) begin
              ram_we = 1'b1;
            end
          end
        end
      end
      S_FETCH: begin
        ram_re     = 1'b1;
        raddr      = dec_now.xx;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          res_ld     = 1'b1;
          state_next = S_IDLE;
          unique case (dec.op)
            lmc_pkg::OP_HALT: status_next = lmc_pkg::ST_HALT;
            lmc_pkg::OP_IN: begin
              acc_next            = cur_inbox;
              res_next.inbox_used = 1'b1;
              adv                 = 1'b1;
            end
            lmc_pkg::OP_OUT: begin
              res_next.out_valid = 1'b1;
              res_next.out_value = acc;
              adv                = 1'b1;
            end
            lmc_pkg::OP_ADD: begin
              acc_next = acc + mem_word;
              adv      = 1'b1;
            end
            lmc_pkg::OP_SUB: begin
              acc_next = diff;
              neg_next = diff[lmc_pkg::WORD_W-1];
              adv      = 1'b1;
            end
            lmc_pkg::OP_STO: begin
              ram_we = 1'b1;
              waddr  = dec.xx;
              wdata  = acc;
              adv    = 1'b1;
            end
            lmc_pkg::OP_LDA: begin
              acc_next = mem_word;
              adv      = 1'b1;
            end
            lmc_pkg::OP_BRA: pc_next = dec.xx;
            lmc_pkg::OP_BRZ: begin
              if (acc == '0) pc_next = dec.xx;
              else adv = 1'b1;
            end
            lmc_pkg::OP_BRP: begin
              if (!acc[lmc_pkg::WORD_W-1]) pc_next = dec.xx;
              else adv = 1'b1;
            end
            default: status_next = lmc_pkg::ST_BAD;
          endcase
          if (adv) begin
            pc_next = pc_inc;
            if (pc_inc == lmc_pkg::ADDR_W'(lmc_pkg::MBOX_COUNT)) begin
              status_next = lmc_pkg::ST_END;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    res_next.run_status = status_next;
    res_next.pc_now     = pc_next;
    res_next.acc_now    = acc_next;
    res_next.neg_now    = neg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      acc       <= '0;
      neg       <= 1'b0;
      status    <= lmc_pkg::ST_RUN;
      vbit      <= '0;
      ib_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      acc    <= acc_next;
      neg    <= neg_next;
      status <= status_next;
      if (ram_we) begin
        vbit[waddr] <= 1'b1;
      end
      if (in_valid && in_ready) begin
        ib_valid <= 1'b1;
      end else if (pop) begin
        ib_valid <= 1'b0;
      end
      if (res_ld) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_data;
    end
    if (cur_ld) begin
      cur_inbox <= ib.inbox_value;
    end
    if (ram_re) begin
      rd_ok <= vbit[raddr];
    end
    if (state == S_FETCH) begin
      dec <= dec_now;
    end
    if (res_ld) begin
      res_data <= res_next;
    end
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> waddr < lmc_pkg::ADDR_W'(lmc_pkg::MBOX_COUNT))
    else $error("mailbox write beyond the last entry");

  a_run_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    status == lmc_pkg::ST_RUN |-> pc < lmc_pkg::ADDR_W'(lmc_pkg::MBOX_COUNT))
    else $error("running with the program counter past the last mailbox");

  a_stopped_no_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && status != lmc_pkg::ST_RUN) |=> state != S_FETCH)
    else $error("instruction fetch on a stopped machine");

  a_exec_after_fetch: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> ($past(state) == S_FETCH || $past(state) == S_EXEC))
    else $error("execute without a preceding fetch");

  a_buffer_kept: assert property (@(posedge clk) disable iff (rst)
    (ib_valid && !pop) |=> ib_valid)
    else $error("buffered transaction dropped");

endmodule
